@@ rtl/core/lsi_pkg.sv @@
// Shared types, constants and the six-tap kernel for the luma interpolator.
package lsi_pkg;

  localparam int PIX_W     = 8;
  localparam int MID_W     = 15;
  localparam int SUM_W     = 22;
  localparam int POS_W     = 4;
  localparam int TAPS_KEPT = 5;
  localparam int ROUND_ADD = 512;
  localparam int OUT_SHIFT = 10;
  localparam int PIX_MAX   = 255;

  typedef logic        [PIX_W-1:0] pixel_t;
  typedef logic signed [MID_W-1:0] mid_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic        [POS_W-1:0] pos_t;

  typedef struct packed {
    mid_t [TAPS_KEPT:0] tap;
    pixel_t             dst;
    pos_t               row;
    pos_t               col;
    logic               last;
  } lsi_stage_t;

  function automatic sum_t six_tap(sum_t a, sum_t b, sum_t c, sum_t d, sum_t e, sum_t f);
    return sum_t'(20 * (c + d) - 5 * (b + e) + (a + f));
  endfunction

  function automatic sum_t pix_to_sum(pixel_t p);
    return sum_t'($signed({1'b0, p}));
  endfunction

endpackage

@@ rtl/core/lsi_if.sv @@
// Handshake interfaces for the pixel input, result output and mode write channels.
interface lsi_pix_if;
  logic          valid;
  logic          ready;
  lsi_pkg::pixel_t src_pixel;
  lsi_pkg::pixel_t dst_pixel;
  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface lsi_res_if;
  logic          valid;
  logic          ready;
  lsi_pkg::pixel_t out_pixel;
  lsi_pkg::pos_t   out_row;
  lsi_pkg::pos_t   out_col;
  logic          last_of_block;
  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output last_of_block, input ready);
  modport sink (input valid, input out_pixel, input out_row, input out_col,
                input last_of_block, output ready);
endinterface

interface lsi_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/lsi_tap_cell.sv @@
// One storage cell of a shift chain that passes its value on when enabled.
module lsi_tap_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

@@ rtl/core/lsi_filter.sv @@
// Vertical six-tap pass, rounding, clamping and optional averaging of one pixel.
module lsi_filter (
  input  lsi_pkg::lsi_stage_t stage,
  input  logic                avg_mode,
  output lsi_pkg::pixel_t     pixel
);
  import lsi_pkg::*;

  sum_t               acc;
  sum_t               rnd;
  logic [SUM_W-1:0]   quo;
  pixel_t             clamped;
  logic [PIX_W:0]     avg_sum;

  always_comb begin
    acc = six_tap(sum_t'(stage.tap[0]), sum_t'(stage.tap[1]), sum_t'(stage.tap[2]),
                  sum_t'(stage.tap[3]), sum_t'(stage.tap[4]), sum_t'(stage.tap[5]));
    rnd = acc + sum_t'(ROUND_ADD);
    quo = SUM_W'(rnd >>> OUT_SHIFT);
    if (rnd[SUM_W-1]) begin
      clamped = '0;
    end else if (quo > SUM_W'(PIX_MAX)) begin
      clamped = PIX_W'(PIX_MAX);
    end else begin
      clamped = quo[PIX_W-1:0];
    end
    avg_sum = {1'b0, clamped} + {1'b0, stage.dst} + (PIX_W+1)'(1);
    pixel = avg_mode ? avg_sum[PIX_W:1] : clamped;
  end

endmodule

@@ rtl/core/luma_sixtap_2d_interpolator.sv @@
// Top level of the luma six-tap two-dimensional half-pel interpolator.
//
//   channel  dir  beat contents
//   pix      in   src_pixel, dst_pixel (one window pixel, raster order)
//   res      out  out_pixel, out_row, out_col, last_of_block
//   cfg      in   data (avg_mode)
//
// One pixel beat is taken every cycle while pix.ready is high; a result is registered
// in s1 with the beat that completes it and then, filtered, in the res registers.
// Reset clears the window position, the pipeline valids and avg_mode; the shift
// chains hold unwritten data until the window fills them.
// A stalled result holds the pipeline; pix.ready drops only when both stages are full.
module luma_sixtap_2d_interpolator #(
  parameter int BLOCK_SIZE = 16
) (
  input logic    clk,
  input logic    rst,
  lsi_pix_if.sink   pix,
  lsi_res_if.source res,
  lsi_cfg_if.sink   cfg
);
  import lsi_pkg::*;

  localparam int WIN   = BLOCK_SIZE + TAPS_KEPT;
  localparam int CNT_W = $clog2(WIN);
  localparam int CHAIN = TAPS_KEPT * BLOCK_SIZE;

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic             avg_mode;
  logic             s1_valid;
  lsi_stage_t       s1;
  pixel_t           filt_pixel;

  logic             pix_acc;
  logic             out_load;
  logic             col_in;
  logic             produce;
  logic [CNT_W-1:0] x;
  logic [CNT_W-1:0] y;
  mid_t             mid;
  lsi_stage_t       s1_next;

  pixel_t rw [TAPS_KEPT+1];
  mid_t   chain [CHAIN+1];

  assign cfg.ready = 1'b1;
  assign out_load  = !res.valid || res.ready;
  assign pix.ready = !s1_valid || out_load;
  assign pix_acc   = pix.valid && pix.ready;

  assign rw[TAPS_KEPT] = pix.src_pixel;
  assign chain[0]      = mid;

  for (genvar i = 0; i < TAPS_KEPT; i++) begin : g_row
    lsi_tap_cell #(.W(PIX_W)) u_cell (
      .clk (clk),
      .en  (pix_acc),
      .d   (rw[i+1]),
      .q   (rw[i])
    );
  end

  for (genvar i = 0; i < CHAIN; i++) begin : g_col
    lsi_tap_cell #(.W(MID_W)) u_cell (
      .clk (clk),
      .en  (pix_acc && col_in),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  always_comb begin
    col_in  = col >= CNT_W'(TAPS_KEPT);
    produce = col_in && (row >= CNT_W'(TAPS_KEPT));
    x       = col - CNT_W'(TAPS_KEPT);
    y       = row - CNT_W'(TAPS_KEPT);
    mid     = mid_t'(six_tap(pix_to_sum(rw[0]), pix_to_sum(rw[1]), pix_to_sum(rw[2]),
                             pix_to_sum(rw[3]), pix_to_sum(rw[4]), pix_to_sum(rw[5])));
    for (int k = 0; k < TAPS_KEPT; k++) begin
      s1_next.tap[k] = chain[(TAPS_KEPT - k) * BLOCK_SIZE];
    end
    s1_next.tap[TAPS_KEPT] = mid;
    s1_next.dst  = pix.dst_pixel;
    s1_next.row  = y[POS_W-1:0];
    s1_next.col  = x[POS_W-1:0];
    s1_next.last = (y == CNT_W'(BLOCK_SIZE - 1)) && (x == CNT_W'(BLOCK_SIZE - 1));
  end

  lsi_filter u_filter (
    .stage    (s1),
    .avg_mode (avg_mode),
    .pixel    (filt_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      avg_mode  <= 1'b0;
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        avg_mode <= cfg.data;
      end
      if (out_load) begin
        res.valid <= s1_valid;
      end
      if (pix_acc) begin
        s1_valid <= produce;
        if (col == CNT_W'(WIN - 1)) begin
          col <= '0;
          row <= (row == CNT_W'(WIN - 1)) ? '0 : row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && produce) begin
      s1 <= s1_next;
    end
    if (out_load && s1_valid) begin
      res.out_pixel     <= filt_pixel;
      res.out_row       <= s1.row;
      res.out_col       <= s1.col;
      res.last_of_block <= s1.last;
    end
  end

endmodule
